FILE: src/nsqrt_pkg.sv
// Shared constants for the Newton square root block.
package nsqrt_pkg;

    // Width and reset value of the iteration limit register.
    localparam int LIMIT_WIDTH = 7;
    localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 7'd40;

endpackage

FILE: src/newton_square_root.sv
// Top level of the Newton square root block: sequencer, estimate and result word.
//
//  Channel  | Handshake                | Data
//  ---------+--------------------------+------------------------------
//  config   | i_cfg_valid/o_cfg_ready  | i_cfg_data (iteration limit)
//  input    | i_in_valid/o_in_ready    | i_radicand
//  output   | o_out_valid/i_out_ready  | o_root, o_limit_hit
//
// A zero radicand skips the Newton steps and goes straight to the final state.
// Otherwise each Newton step runs the shared bit-serial divider once,
// over DATA_WIDTH + FRACTION_BITS bits.
// Reset is synchronous and sets the iteration limit to 40.
// A new word is taken while a finished result waits; the next result waits
// in its final state until the output register is free.
module newton_square_root #(
    parameter int DATA_WIDTH    = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  logic [nsqrt_pkg::LIMIT_WIDTH-1:0]           i_cfg_data,
    input  logic                                        i_in_valid,
    output logic                                        o_in_ready,
    input  logic [DATA_WIDTH-1:0]                       i_radicand,
    output logic                                        o_out_valid,
    input  logic                                        i_out_ready,
    output logic [(DATA_WIDTH+FRACTION_BITS+1)/2-1:0]   o_root,
    output logic                                        o_limit_hit
);
    import nsqrt_pkg::*;

    localparam int NW = DATA_WIDTH + FRACTION_BITS;
    localparam int RW = (NW + 1) / 2;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_CHECK  = 5'b00010,
        S_DIV    = 5'b00100,
        S_UPDATE = 5'b01000,
        S_FINISH = 5'b10000
    } t_state;

    t_state                 r_state, n_state;
    logic [LIMIT_WIDTH-1:0] r_limit;
    logic [LIMIT_WIDTH-1:0] r_steps, n_steps;
    logic [NW-1:0]          r_n, n_n;
    logic [NW-1:0]          r_x, n_x;
    logic                   r_hit, n_hit;
    logic                   r_out_valid, n_out_valid;
    logic [RW-1:0]          r_root, n_root;
    logic                   r_out_hit, n_out_hit;
    logic                   div_start;
    logic                   div_done;
    logic [NW-1:0]          div_quo;
    logic [NW:0]            sum;
    logic [NW-1:0]          x_next;
    logic [RW-1:0]          root_sat;

    nsqrt_div #(
        .WIDTH(NW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_n),
        .i_divisor  (r_x),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // Newton update and saturation of the estimate to the root field.
    always_comb begin
        sum      = {1'b0, r_x} + {1'b0, div_quo};
        x_next   = sum[NW:1];
        root_sat = (r_x[NW-1:RW] != '0) ? {RW{1'b1}} : r_x[RW-1:0];
    end

    // Sequencer.
    always_comb begin
        n_state     = r_state;
        n_steps     = r_steps;
        n_n         = r_n;
        n_x         = r_x;
        n_hit       = r_hit;
        n_out_valid = r_out_valid && !i_out_ready;
        n_root      = r_root;
        n_out_hit   = r_out_hit;
        div_start   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_steps = '0;
                    n_hit   = 1'b0;
                    n_n     = NW'(i_radicand) << FRACTION_BITS;
                    if (i_radicand == '0) begin
                        n_x     = '0;
                        n_state = S_FINISH;
                    end else begin
                        n_x     = (i_radicand[DATA_WIDTH-1:1] == '0) ? NW'(1)
                                                                    : NW'(i_radicand >> 1);
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (r_steps >= r_limit) begin
                    n_hit   = 1'b1;
                    n_state = S_FINISH;
                end else begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                n_steps = r_steps + 1'b1;
                if (r_steps != '0 && x_next >= r_x) begin
                    n_state = S_FINISH;
                end else begin
                    n_x     = (x_next == '0) ? NW'(1) : x_next;
                    n_state = S_CHECK;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_root      = root_sat;
                    n_out_hit   = r_hit;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_limit     <= LIMIT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
        end
    end

    // Data registers.
    always_ff @(posedge i_clk) begin
        r_steps   <= n_steps;
        r_n       <= n_n;
        r_x       <= n_x;
        r_hit     <= n_hit;
        r_root    <= n_root;
        r_out_hit <= n_out_hit;
    end

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_root      = r_root;
    assign o_limit_hit = r_out_hit;

endmodule

FILE: src/nsqrt_div.sv
// Shared restoring divider, one quotient bit per cycle.
module nsqrt_div #(
    parameter int WIDTH = 48
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_dividend,
    input  logic [WIDTH-1:0] i_divisor,
    output logic             o_done,
    output logic [WIDTH-1:0] o_quotient
);
    import nsqrt_pkg::*;

    localparam int CNT_WIDTH = $clog2(WIDTH + 1);

    logic [WIDTH-1:0]     r_rem;
    logic [WIDTH-1:0]     r_quo;
    logic [WIDTH-1:0]     r_dsr;
    logic [CNT_WIDTH-1:0] r_cnt;
    logic                 r_done;
    logic [WIDTH:0]       rem_shift;
    logic [WIDTH:0]       rem_diff;
    logic                 fits;

    // One restoring step: shift in the next dividend bit and try to subtract.
    always_comb begin
        rem_shift = {r_rem, r_quo[WIDTH-1]};
        rem_diff  = rem_shift - {1'b0, r_dsr};
        fits      = (rem_shift >= {1'b0, r_dsr});
    end

    // Step counter and done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_WIDTH'(WIDTH);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_WIDTH'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient shift registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem <= fits ? rem_diff[WIDTH-1:0] : rem_shift[WIDTH-1:0];
            r_quo <= {r_quo[WIDTH-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

FILE: src/nsqrt_checker.sv
// Port checker for the Newton square root block, bound to the top level.
module nsqrt_checker #(
    parameter int DATA_WIDTH    = 32,
    parameter int FRACTION_BITS = 16
) (
    input logic                                      i_clk,
    input logic                                      i_rst_n,
    input logic                                      i_cfg_valid,
    input logic                                      o_cfg_ready,
    input logic [nsqrt_pkg::LIMIT_WIDTH-1:0]         i_cfg_data,
    input logic                                      i_in_valid,
    input logic                                      o_in_ready,
    input logic [DATA_WIDTH-1:0]                     i_radicand,
    input logic                                      o_out_valid,
    input logic                                      i_out_ready,
    input logic [(DATA_WIDTH+FRACTION_BITS+1)/2-1:0] o_root,
    input logic                                      o_limit_hit
);
    import nsqrt_pkg::*;

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its word.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_root) && $stable(o_limit_hit))
        else $error("result word changed while stalled");

    // The block works on one radicand at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while a word is in work");

    // Reset leaves no result pending.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result pending after reset");

endmodule

bind newton_square_root nsqrt_checker #(
    .DATA_WIDTH    (DATA_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
) u_nsqrt_checker (.*);

FILE: tb/newton_root_checker.sv
// Checker for the Newton square root block: predicts each result word and compares it.
`timescale 1ns / 1ps

module newton_root_checker #(
    parameter int DATA_WIDTH    = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_cfg_valid,
    input  logic                                        i_cfg_ready,
    input  logic [nsqrt_pkg::LIMIT_WIDTH-1:0]           i_cfg_data,
    input  logic                                        i_in_valid,
    input  logic                                        i_in_ready,
    input  logic [DATA_WIDTH-1:0]                       i_radicand,
    input  logic                                        i_out_valid,
    input  logic                                        i_out_ready,
    input  logic [(DATA_WIDTH+FRACTION_BITS+1)/2-1:0]   i_root,
    input  logic                                        i_limit_hit,
    output int                                          o_fail_count,
    output int                                          o_pending_count
);

    localparam int ROOT_WIDTH = (DATA_WIDTH + FRACTION_BITS + 1) / 2;
    localparam logic [63:0] ROOT_MAX = (64'd1 << ROOT_WIDTH) - 64'd1;

    typedef struct packed {
        logic [ROOT_WIDTH-1:0] root;
        logic                  limit_hit;
    } t_root_word;

    logic [nsqrt_pkg::LIMIT_WIDTH-1:0] step_limit;
    t_root_word                        expected_roots [$];

    // Fixed-point Newton iteration on N = R << FRACTION_BITS, starting from R / 2.
    function automatic t_root_word newton_root(input logic [DATA_WIDTH-1:0] rad,
                                               input logic [nsqrt_pkg::LIMIT_WIDTH-1:0] lim);
        logic [63:0] n;
        logic [63:0] x;
        logic [63:0] nx;
        int unsigned steps;
        t_root_word  w;
        w.root      = '0;
        w.limit_hit = 1'b0;
        if (rad == '0) begin
            return w;
        end
        n     = 64'(rad) << FRACTION_BITS;
        x     = 64'(rad) >> 1;
        steps = 0;
        if (x == 64'd0) begin
            x = 64'd1;
        end
        while (1) begin
            // The limit wins even on the step that would have converged.
            if (steps >= lim) begin
                w.limit_hit = 1'b1;
                break;
            end
            nx = (x + n / x) >> 1;
            steps++;
            if (steps > 1 && nx >= x) begin
                break;
            end
            x = nx;
            if (x == 64'd0) begin
                x = 64'd1;
            end
        end
        // An unconverged estimate can be wider than the root field.
        w.root = (x > ROOT_MAX) ? ROOT_MAX[ROOT_WIDTH-1:0] : x[ROOT_WIDTH-1:0];
        return w;
    endfunction

    // Track the limit register, queue predictions and compare each result word.
    always @(posedge i_clk) begin
        t_root_word want;
        if (!i_rst_n) begin
            step_limit = nsqrt_pkg::LIMIT_RESET;
            expected_roots.delete();
            o_fail_count    <= 0;
            o_pending_count <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                step_limit = i_cfg_data;
            end
            if (i_in_valid && i_in_ready) begin
                expected_roots.push_back(newton_root(i_radicand, step_limit));
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_roots.size() == 0) begin
                    $error("result word with nothing expected: root %0d, limit_hit %0d",
                           i_root, i_limit_hit);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_roots.pop_front();
                    if (i_root !== want.root || i_limit_hit !== want.limit_hit) begin
                        o_fail_count <= o_fail_count + 1;
                    end
                    if (i_root !== want.root) begin
                        $error("root mismatch: expected %0d, actual %0d", want.root, i_root);
                    end
                    if (i_limit_hit !== want.limit_hit) begin
                        $error("limit_hit mismatch: expected %0d, actual %0d",
                               want.limit_hit, i_limit_hit);
                    end
                end
            end
            o_pending_count <= expected_roots.size();
        end
    end

endmodule

FILE: tb/newton_square_root_tb.sv
// Top of the Newton square root testbench: clock, reset, stimulus, stalls and verdict.
`timescale 1ns / 1ps

module newton_square_root_tb;

    localparam int DATA_WIDTH    = 32;
    localparam int FRACTION_BITS = 16;
    localparam int ROOT_WIDTH    = (DATA_WIDTH + FRACTION_BITS + 1) / 2;
    localparam int PHASES        = 10;
    localparam int FIRST_ITEMS   = 60;
    localparam int PHASE_ITEMS   = 40;
    localparam int HOLD_AT       = 30;
    localparam int HOLD_CYCLES   = 3000;
    localparam int TAIL_CYCLES   = 1500;
    localparam int IDLE_LIMIT    = 20000;

    typedef enum int {
        READY_ALWAYS,
        READY_COIN,
        READY_SPARSE,
        READY_PERIODIC
    } t_ready_mode;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n;
    logic                              i_cfg_valid;
    logic                              o_cfg_ready;
    logic [nsqrt_pkg::LIMIT_WIDTH-1:0] i_cfg_data;
    logic                              i_in_valid;
    logic                              o_in_ready;
    logic [DATA_WIDTH-1:0]             i_radicand;
    logic                              o_out_valid;
    logic                              i_out_ready;
    logic [ROOT_WIDTH-1:0]             o_root;
    logic                              o_limit_hit;

    int fail_count;
    int pending_count;
    int idle_cycles;
    int burst_left;

    newton_square_root #(
        .DATA_WIDTH   (DATA_WIDTH),
        .FRACTION_BITS(FRACTION_BITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_radicand (i_radicand),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_root     (o_root),
        .o_limit_hit(o_limit_hit)
    );

    newton_root_checker #(
        .DATA_WIDTH   (DATA_WIDTH),
        .FRACTION_BITS(FRACTION_BITS)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_radicand     (i_radicand),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_root         (o_root),
        .i_limit_hit    (o_limit_hit),
        .o_fail_count   (fail_count),
        .o_pending_count(pending_count)
    );

    // Free-running clock, 12 ns period.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Watchdog: end the run when no word moves on any channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((i_cfg_valid && o_cfg_ready) || (i_in_valid && o_in_ready)
                     || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $error("no word accepted for %0d cycles", idle_cycles);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Offer one radicand word and hold it until accepted; bursts end in random gaps.
    task automatic send_word(input logic [DATA_WIDTH-1:0] w);
        int gap;
        i_in_valid <= 1'b1;
        i_radicand <= w;
        do @(posedge i_clk); while (!o_in_ready);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Stop offering words until every predicted result word has come back.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
    endtask

    // Write the iteration limit register; only called while the block is idle.
    task automatic write_limit(input logic [nsqrt_pkg::LIMIT_WIDTH-1:0] lim);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= lim;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // Receiver: changing stall patterns plus one long hold-off to back up the block.
    initial begin
        t_ready_mode mode;
        int          span;
        int          period;
        int          tick;
        int          results_seen;
        bit          held;
        results_seen = 0;
        held         = 1'b0;
        tick         = 0;
        i_out_ready  = 1'b0;
        forever begin
            mode   = t_ready_mode'($urandom_range(0, 3));
            span   = $urandom_range(50, 400);
            period = $urandom_range(2, 9);
            repeat (span) begin
                @(posedge i_clk);
                tick++;
                if (o_out_valid && i_out_ready) begin
                    results_seen++;
                end
                if (results_seen == HOLD_AT && !held) begin
                    held = 1'b1;
                    i_out_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge i_clk);
                end else begin
                    case (mode)
                        READY_ALWAYS:   i_out_ready <= 1'b1;
                        READY_COIN:     i_out_ready <= 1'($urandom_range(0, 1));
                        READY_SPARSE:   i_out_ready <= ($urandom_range(0, 7) == 0);
                        READY_PERIODIC: i_out_ready <= ((tick % period) == 0);
                        default:        i_out_ready <= 1'b1;
                    endcase
                end
            end
        end
    end

    // Stimulus: corner words under the reset limit, then random words over many limits.
    initial begin
        logic [DATA_WIDTH-1:0]             w;
        logic [nsqrt_pkg::LIMIT_WIDTH-1:0] lim;
        int                                m;
        int                                items;
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_radicand  = '0;
        burst_left  = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Corner words: zero, tiny values, exact squares, all ones and alternating bits.
        send_word(32'h0000_0000);
        send_word(32'h0000_0001);
        send_word(32'h0000_0002);
        send_word(32'h0000_0003);
        send_word(32'h0001_0000);
        send_word(32'h0004_0000);
        send_word(32'h0000_0100);
        send_word(32'h0000_8000);
        send_word(32'h7FFF_FFFF);
        send_word(32'h8000_0000);
        send_word(32'hFFFF_FFFE);
        send_word(32'hFFFF_FFFF);
        send_word(32'hAAAA_AAAA);
        send_word(32'h5555_5555);
        send_word(32'hFFFE_0001);
        send_word(32'h0000_0000);

        for (int phase = 0; phase < PHASES; phase++) begin
            // Each later phase starts from an idle block with a new limit.
            if (phase > 0) begin
                case (phase)
                    1:       lim = 7'd1;
                    2:       lim = 7'd64;
                    3:       lim = 7'd0;
                    4:       lim = 7'd127;
                    9:       lim = nsqrt_pkg::LIMIT_RESET;
                    default: lim = 7'($urandom_range(2, 12));
                endcase
                drain_results();
                write_limit(lim);
            end
            items = (phase == 0) ? FIRST_ITEMS : PHASE_ITEMS;
            for (int k = 0; k < items; k++) begin
                if (phase == 2 && k == 20) begin
                    drain_results();
                end
                case ($urandom_range(0, 5))
                    0: w = $urandom;
                    1: w = $urandom_range(0, 255);
                    2: begin
                        // Near an exact square of the radicand.
                        m = $urandom_range(0, 65535);
                        w = 32'(m * m) + 32'($urandom_range(0, 2)) - 32'd1;
                    end
                    3: w = 32'hFFFF_0000 | 32'($urandom_range(0, 65535));
                    4: w = 32'd1 << $urandom_range(0, 31);
                    default: w = 32'hFFFF_FFFF >> $urandom_range(0, 31);
                endcase
                send_word(w);
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_count != 0) begin
            $error("%0d result words never arrived", pending_count);
        end
        if (fail_count == 0 && pending_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: sim.f
src/nsqrt_pkg.sv
src/nsqrt_div.sv
src/newton_square_root.sv
src/nsqrt_checker.sv
tb/newton_root_checker.sv
tb/newton_square_root_tb.sv
